### hdl/msprc_pkg.sv
// Package for the RC channel store and MSP frame encoder.
// Holds opcodes, register indexes, reset values and the queue entry type.
// No dependencies.
package msprc_pkg;

  // Default channel count of the store.
  localparam int DEF_NUM_CHANNELS = 8;

  // Depth of the request queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Frame header bytes.
  localparam logic [7:0] HDR_DOLLAR = 8'h24;
  localparam logic [7:0] HDR_EM     = 8'h4D;
  localparam logic [7:0] HDR_TO_FC  = 8'h3C;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;

  // Configuration register reset values.
  localparam logic [15:0] RST_VALUE_MIN      = 16'd1000;
  localparam logic [15:0] RST_VALUE_MAX      = 16'd2000;
  localparam logic [15:0] RST_VALUE_MID      = 16'd1500;
  localparam logic [3:0]  RST_THROTTLE_INDEX = 4'd3;
  localparam logic [7:0]  RST_COMMAND_ID     = 8'd200;

  // Configuration register indexes.
  localparam logic [2:0] REG_VALUE_MIN      = 3'd0;
  localparam logic [2:0] REG_VALUE_MAX      = 3'd1;
  localparam logic [2:0] REG_VALUE_MID      = 3'd2;
  localparam logic [2:0] REG_THROTTLE_INDEX = 3'd3;
  localparam logic [2:0] REG_COMMAND_ID     = 3'd4;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_GET  = 2'd1,
    OP_SEND = 2'd2,
    OP_INIT = 2'd3
  } opcode_t;

  // States of the back-end sequencer.
  typedef enum logic [1:0] {
    B_IDLE,
    B_GET,
    B_SEND
  } back_state_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    opcode_t     op;
    logic [3:0]  index;
    logic        in_range;
    logic [15:0] value;
  } msprc_cmd_t;

endpackage

### hdl/msprc_queue.sv
// Small FIFO of classified requests between the front and back ends.
// Depends on msprc_pkg for the entry type and depth.
module msprc_queue import msprc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  msprc_cmd_t din,
  input  logic       pop,
  output msprc_cmd_t dout,
  output logic       empty,
  output logic       full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  msprc_cmd_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign empty = (count == CNT_W'(0));
  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign dout  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Pointers wrap at the queue depth; the fill count tracks pushes less pops.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/msprc_front.sv
// Front end: accepts requests, checks the channel range and clamps set values.
// Depends on msprc_pkg; feeds msprc_queue.
module msprc_front import msprc_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [3:0]  channel_index,
  input  logic [15:0] channel_value,
  input  logic [15:0] value_min,
  input  logic [15:0] value_max,
  input  logic        q_full,
  output logic        push,
  output msprc_cmd_t  item
);

  logic        accept;
  logic        in_range;
  logic [15:0] raised;
  opcode_t     op;

  assign op     = opcode_t'(opcode);
  assign busy   = q_full;
  assign accept = start && !q_full;

  // Range check and clamp: raise to the minimum first, then lower to the maximum.
  always_comb begin
    in_range = ({1'b0, channel_index} < 5'(NUM_CHANNELS));
    raised   = (channel_value < value_min) ? value_min : channel_value;
    item.op       = op;
    item.index    = channel_index;
    item.in_range = in_range;
    item.value    = (raised > value_max) ? value_max : raised;
  end

  // A set to a channel outside the store has no effect and is dropped here.
  assign push = accept && !((op == OP_SET) && !in_range);

endmodule

### hdl/msprc_back.sv
// Back end: channel store, read path and the byte sequencer of the frame.
// Depends on msprc_pkg; pops requests from msprc_queue.
module msprc_back import msprc_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  msprc_cmd_t  q_head,
  output logic        pop,
  input  logic [15:0] value_min,
  input  logic [15:0] value_mid,
  input  logic [3:0]  throttle_index,
  input  logic [7:0]  command_id,
  output logic        strobe,
  output logic        kind,
  output logic [7:0]  frame_byte,
  output logic [15:0] read_value,
  output logic        last
);

  localparam int IW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int LAST_POS = 5 + 2 * NUM_CHANNELS;
  localparam int POS_W    = $clog2(LAST_POS + 2);
  localparam logic [7:0] LEN_BYTE = 8'((2 * NUM_CHANNELS) % 256);

  back_state_t       state, state_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [7:0]        sum, sum_next;
  logic              get_hit, get_hit_next;

  // Channel store; an entry without its valid bit reads as its init default.
  logic [15:0]             mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] entry_valid;
  logic [15:0]             init_min;
  logic [15:0]             init_mid;
  logic [3:0]              init_thr;

  logic [15:0]       rd_data;
  logic              rd_valid;
  logic [15:0]       rd_def;
  logic [15:0]       entry_value;

  logic              wr_en;
  logic              do_init;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;

  logic              strobe_next;
  logic              kind_next;
  logic [7:0]        byte_next;
  logic [15:0]       value_next;
  logic              last_next;

  logic [POS_W-1:0]  offset;
  logic [POS_W-1:0]  ch_plus;
  logic [7:0]        send_byte;

  assign entry_value = rd_valid ? rd_data : rd_def;
  assign offset      = pos - POS_W'(5);
  assign ch_plus     = {1'b0, offset[POS_W-1:1]} + POS_W'(1);

  // Byte of the frame at the current position.
  always_comb begin
    if (pos == POS_W'(0)) begin
      send_byte = HDR_DOLLAR;
    end else if (pos == POS_W'(1)) begin
      send_byte = HDR_EM;
    end else if (pos == POS_W'(2)) begin
      send_byte = HDR_TO_FC;
    end else if (pos == POS_W'(3)) begin
      send_byte = LEN_BYTE;
    end else if (pos == POS_W'(4)) begin
      send_byte = command_id;
    end else if (pos == POS_W'(LAST_POS)) begin
      send_byte = sum;
    end else if (offset[0]) begin
      send_byte = entry_value[15:8] & BYTE_MASK;
    end else begin
      send_byte = entry_value[7:0] & BYTE_MASK;
    end
  end

  // State register and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      pos     <= '0;
      sum     <= '0;
      get_hit <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      sum     <= sum_next;
      get_hit <= get_hit_next;
      strobe  <= strobe_next;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    kind       <= kind_next;
    frame_byte <= byte_next;
    read_value <= value_next;
    last       <= last_next;
  end

  // Next state, queue pop, store access and result fields.
  always_comb begin
    state_next   = state;
    pos_next     = pos;
    sum_next     = sum;
    get_hit_next = get_hit;
    pop          = 1'b0;
    wr_en        = 1'b0;
    do_init      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    strobe_next  = 1'b0;
    kind_next    = 1'b0;
    byte_next    = '0;
    value_next   = '0;
    last_next    = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          unique case (q_head.op)
            OP_SET: begin
              wr_en = 1'b1;
            end
            OP_GET: begin
              rd_en        = q_head.in_range;
              rd_addr      = q_head.index[IW-1:0];
              get_hit_next = q_head.in_range;
              state_next   = B_GET;
            end
            OP_SEND: begin
              pos_next   = '0;
              sum_next   = '0;
              state_next = B_SEND;
            end
            OP_INIT: begin
              do_init = 1'b1;
            end
            default: begin
              state_next = B_IDLE;
            end
          endcase
        end
      end
      B_GET: begin
        strobe_next = 1'b1;
        kind_next   = 1'b1;
        last_next   = 1'b1;
        value_next  = get_hit ? entry_value : value_mid;
        state_next  = B_IDLE;
      end
      B_SEND: begin
        strobe_next = 1'b1;
        byte_next   = send_byte;
        last_next   = (pos == POS_W'(LAST_POS));
        if ((pos >= POS_W'(3)) && (pos < POS_W'(LAST_POS))) begin
          sum_next = sum ^ send_byte;
        end
        // Fetch channel 0 on the command byte, the next channel on each high byte.
        if (pos == POS_W'(4)) begin
          rd_en = 1'b1;
        end else if ((pos > POS_W'(4)) && (pos < POS_W'(LAST_POS)) && offset[0] &&
                     (ch_plus < POS_W'(NUM_CHANNELS))) begin
          rd_en   = 1'b1;
          rd_addr = ch_plus[IW-1:0];
        end
        if (pos == POS_W'(LAST_POS)) begin
          state_next = B_IDLE;
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Store write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_head.index[IW-1:0]] <= q_head.value;
    end
  end

  // Store read port with the valid bit and default read alongside.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= entry_valid[rd_addr];
      rd_def   <= (5'(rd_addr) == {1'b0, init_thr}) ? init_min : init_mid;
    end
  end

  // Valid bits and init defaults; init clears every entry back to its default.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      init_min    <= RST_VALUE_MIN;
      init_mid    <= RST_VALUE_MID;
      init_thr    <= RST_THROTTLE_INDEX;
    end else if (do_init) begin
      entry_valid <= '0;
      init_min    <= value_min;
      init_mid    <= value_mid;
      init_thr    <= throttle_index;
    end else if (wr_en) begin
      entry_valid[q_head.index[IW-1:0]] <= 1'b1;
    end
  end

endmodule

### hdl/msp_rc_frame_encoder_top.sv
// Top level of the RC channel store and MSP v1 frame encoder.
// Depends on msprc_pkg, msprc_front, msprc_queue and msprc_back.
//
// Usage:
//   Requests enter on start/opcode/channel_index/channel_value and are taken
//   at a clock edge where start is high and busy is low. Results leave on
//   kind/frame_byte/read_value/last, each valid for exactly one cycle while
//   strobe is high; the receiver cannot hold them off.
//   A set or init request is done as the back end pops it; a get is popped,
//   then reads the store, then gives its result; a send is popped, then the
//   byte sequencer gives one frame byte per cycle.
//   With the back end idle, a taken request passes the queue entry, the
//   back-end state register and the result registers before its first
//   result is on the ports. A two-entry queue lets the front take further
//   requests while a frame is being sent; busy rises only when that queue
//   is full.
//   Reset clears the queue and the sequencer, loads the register defaults and
//   puts every channel at mid with the throttle channel at min.
//   Registers sit on an APB-style port at byte address 4 * index; write them
//   only when no request is pending.
module msp_rc_frame_encoder_top import msprc_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [3:0]  channel_index,
  input  logic [15:0] channel_value,
  output logic        strobe,
  output logic        kind,
  output logic [7:0]  frame_byte,
  output logic [15:0] read_value,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] value_min;
  logic [15:0] value_max;
  logic [15:0] value_mid;
  logic [3:0]  throttle_index;
  logic [7:0]  command_id;

  logic        cfg_write;
  logic [2:0]  reg_index;

  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  msprc_cmd_t  item;
  msprc_cmd_t  q_head;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      value_min      <= RST_VALUE_MIN;
      value_max      <= RST_VALUE_MAX;
      value_mid      <= RST_VALUE_MID;
      throttle_index <= RST_THROTTLE_INDEX;
      command_id     <= RST_COMMAND_ID;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_VALUE_MIN:      value_min      <= pwdata[15:0];
        REG_VALUE_MAX:      value_max      <= pwdata[15:0];
        REG_VALUE_MID:      value_mid      <= pwdata[15:0];
        REG_THROTTLE_INDEX: throttle_index <= pwdata[3:0];
        REG_COMMAND_ID:     command_id     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_index)
      REG_VALUE_MIN:      prdata = {16'd0, value_min};
      REG_VALUE_MAX:      prdata = {16'd0, value_max};
      REG_VALUE_MID:      prdata = {16'd0, value_mid};
      REG_THROTTLE_INDEX: prdata = {28'd0, throttle_index};
      REG_COMMAND_ID:     prdata = {24'd0, command_id};
      default:            prdata = '0;
    endcase
  end

  // Request intake and classification.
  msprc_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .value_min     (value_min),
    .value_max     (value_max),
    .q_full        (q_full),
    .push          (push),
    .item          (item)
  );

  // Request queue.
  msprc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (item),
    .pop   (pop),
    .dout  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  // Store and frame sequencer.
  msprc_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .pop            (pop),
    .value_min      (value_min),
    .value_mid      (value_mid),
    .throttle_index (throttle_index),
    .command_id     (command_id),
    .strobe         (strobe),
    .kind           (kind),
    .frame_byte     (frame_byte),
    .read_value     (read_value),
    .last           (last)
  );

endmodule
